// ----- rtl/core/tilt_pkg.sv -----
package tilt_pkg;

    localparam int SAMPLES_DEF = 10;
    localparam int FRAC_DEF = 8;
    localparam int AXIS_W = 16;
    localparam int STEPS = 24;
    localparam int ZW = 32;
    localparam logic signed [ZW-1:0] Q24_90 = 32'sd1509949440;

    localparam logic [2:0] CFG_AXIS_SELECT = 3'd0;
    localparam logic [2:0] CFG_SWAP_Y_Z = 3'd1;
    localparam logic [2:0] CFG_GAIN_X = 3'd2;
    localparam logic [2:0] CFG_GAIN_Y = 3'd3;
    localparam logic [2:0] CFG_GAIN_Z = 3'd4;
    localparam logic [2:0] CFG_ANGLE_OFFSET = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SQ1,
        ST_SQ2,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_CORD_INIT,
        ST_CORD,
        ST_ACC,
        ST_BATCH,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic sq1;
        logic sq2;
        logic root_init;
        logic root_step;
        logic cord_init;
        logic cord_step;
        logic acc;
        logic count;
        logic clear;
        logic div_init;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic iter_last;
        logic term_last;
        logic batch_end;
        logic batch_bad;
        logic div_last;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [1:0] axis_select;
        logic       swap_y_z;
        logic [3:0] gain_x;
        logic [3:0] gain_y;
        logic [3:0] gain_z;
        logic [9:0] angle_offset;
    } cfg_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd754974720;
            5'd1:  v = 32'sd445687602;
            5'd2:  v = 32'sd235489088;
            5'd3:  v = 32'sd119537938;
            5'd4:  v = 32'sd60000934;
            5'd5:  v = 32'sd30029717;
            5'd6:  v = 32'sd15018523;
            5'd7:  v = 32'sd7509720;
            5'd8:  v = 32'sd3754917;
            5'd9:  v = 32'sd1877466;
            5'd10: v = 32'sd938734;
            5'd11: v = 32'sd469367;
            5'd12: v = 32'sd234684;
            5'd13: v = 32'sd117342;
            5'd14: v = 32'sd58671;
            5'd15: v = 32'sd29335;
            5'd16: v = 32'sd14668;
            5'd17: v = 32'sd7334;
            5'd18: v = 32'sd3667;
            5'd19: v = 32'sd1833;
            5'd20: v = 32'sd917;
            5'd21: v = 32'sd458;
            5'd22: v = 32'sd229;
            5'd23: v = 32'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/tilt_ctrl.sv -----
module tilt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  tilt_pkg::stat_t stat,
    output tilt_pkg::cmd_t  cmd
);
    import tilt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.sq1 = 1'b1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.sq2 = 1'b1;
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.iter_last)
                begin
                    state_next = ST_CORD_INIT;
                end
            end
            ST_CORD_INIT:
            begin
                cmd.cord_init = 1'b1;
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cord_step = 1'b1;
                if (stat.iter_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = stat.term_last ? ST_BATCH : ST_SETUP;
            end
            ST_BATCH:
            begin
                cmd.count = 1'b1;
                if (!stat.batch_end)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.batch_bad)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.iter_last)
                begin
                    state_next = stat.div_last ? ST_EMIT : ST_DIV_INIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/tilt_dp.sv -----
module tilt_dp #(
    parameter int SAMPLES_PER_ANGLE = tilt_pkg::SAMPLES_DEF,
    parameter int FRAC_BITS = tilt_pkg::FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tilt_pkg::cmd_t                      cmd,
    output tilt_pkg::stat_t                     stat,
    input  tilt_pkg::cfg_t                      cfg,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_first,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_second,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_third,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [17:0]                  tilt_angle
);
    import tilt_pkg::*;

    localparam int N = SAMPLES_PER_ANGLE;
    localparam int TW = FRAC_BITS + 8;
    localparam int NW = $clog2(N + 1);
    localparam int SW = TW + NW + 1;
    localparam int DW = SW + 1;
    localparam int KD = DW + $clog2(N);
    localparam int MW = DW + 2;
    localparam int PW = DW + MW;
    localparam int AW = (FRAC_BITS + 12 > 18) ? FRAC_BITS + 12 : 18;
    localparam int CW = $clog2((DW > STEPS) ? DW : STEPS);
    localparam int RS = 24 - FRAC_BITS;
    localparam int QW = 48;
    localparam int XW = 28;
    localparam logic [ZW:0] RHALF = (ZW+1)'(1) << (RS - 1);
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << KD) + 64'(N) - 64'd1) / 64'(N));
    localparam logic signed [AW-1:0] C90 = AW'(90 * (1 << FRAC_BITS));
    localparam logic signed [AW-1:0] C180 = AW'(180 * (1 << FRAC_BITS));
    localparam logic signed [AW-1:0] C270 = AW'(270 * (1 << FRAC_BITS));
    localparam logic signed [AW-1:0] C360 = AW'(360 * (1 << FRAC_BITS));

    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic all0_reg, yaw0_reg;
    logic signed [AXIS_W-1:0] a_reg, b_reg, c_reg;
    logic en_reg;
    logic [1:0] term_reg;
    logic [31:0] s_reg;
    logic [QW-1:0] n_reg, res_reg, bit_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [CW-1:0] i_reg, last_reg;
    logic [NW-1:0] cnt_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic signed [AW-1:0] avg_reg [3];
    logic bad_reg, yaw_bad_reg;
    logic [1:0] sel_reg;
    logic [DW-1:0] dvd_reg;
    logic out_valid_reg;
    logic signed [17:0] tilt_reg;

    logic signed [19:0] px, py, pz;
    logic signed [AXIS_W-1:0] sx, sy, sz;
    logic signed [AXIS_W-1:0] mul_op;
    logic signed [31:0] prod;
    logic [QW-1:0] root_try;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] zc;
    logic [ZW:0] zmag, zr;
    logic signed [TW-1:0] term;
    logic signed [SW-1:0] sum_sel;
    logic [DW-1:0] div_mag;
    logic [PW-1:0] quot_full;
    logic [DW-1:0] quot;
    logic signed [AW-1:0] xv, yv, zv, angle, angle_w;

    assign px = sample_first * $signed(cfg.gain_x);
    assign py = (cfg.swap_y_z ? sample_third : sample_second) * $signed(cfg.gain_y);
    assign pz = (cfg.swap_y_z ? sample_second : sample_third) * $signed(cfg.gain_z);
    assign sx = px[AXIS_W-1:0];
    assign sy = py[AXIS_W-1:0];
    assign sz = pz[AXIS_W-1:0];

    assign mul_op = cmd.sq1 ? b_reg : c_reg;
    assign prod = mul_op * mul_op;
    assign root_try = res_reg + bit_reg;

    assign dx = y_reg >>> i_reg[4:0];
    assign dy = x_reg >>> i_reg[4:0];

    always_comb
    begin
        if (s_reg == '0)
        begin
            zc = (a_reg > 0) ? Q24_90 : -Q24_90;
        end
        else if (z_reg > Q24_90)
        begin
            zc = Q24_90;
        end
        else if (z_reg < -Q24_90)
        begin
            zc = -Q24_90;
        end
        else
        begin
            zc = z_reg;
        end
        zmag = (zc < 0) ? (ZW+1)'(-zc) : (ZW+1)'(zc);
        zr = (zmag + RHALF) >> RS;
        if (a_reg == '0)
        begin
            term = '0;
        end
        else if (zc < 0)
        begin
            term = -TW'(zr);
        end
        else
        begin
            term = TW'(zr);
        end
    end

    // The rounded average is a reciprocal multiplication that is exact for every
    // magnitude that fits the dividend register.
    assign sum_sel = sum_reg[sel_reg];
    assign div_mag = (sum_sel < 0) ? DW'(-sum_sel) + DW'(N / 2) : DW'(sum_sel) + DW'(N / 2);
    assign quot_full = PW'(dvd_reg) * PW'(RECIP);
    assign quot = DW'(quot_full >> KD);

    always_comb
    begin
        xv = '0;
        yv = '0;
        zv = '0;
        if (sum_reg[0] < 0 && sum_reg[1] > 0)
        begin
            xv = -avg_reg[0];
        end
        if (sum_reg[0] != 0 && sum_reg[1] < 0)
        begin
            xv = C180 + avg_reg[0];
        end
        if (sum_reg[0] > 0 && sum_reg[1] > 0)
        begin
            xv = C360 - avg_reg[0];
        end
        if (sum_reg[1] != 0 && sum_reg[0] < 0)
        begin
            yv = C90 - avg_reg[1];
        end
        if (sum_reg[1] != 0 && sum_reg[0] > 0)
        begin
            yv = C270 + avg_reg[1];
        end
        if (!yaw_bad_reg && sum_reg[2] != 0 && sum_reg[0] < 0)
        begin
            zv = C90 - avg_reg[2];
        end
        if (!yaw_bad_reg && sum_reg[2] != 0 && sum_reg[0] > 0)
        begin
            zv = C270 + avg_reg[2];
        end
        case (cfg.axis_select)
            AXIS_X:  angle = xv;
            AXIS_Y:  angle = yv;
            AXIS_Z:  angle = zv;
            default: angle = '0;
        endcase
        angle_w = angle + (AW'($signed(cfg.angle_offset)) <<< FRAC_BITS);
        if (angle_w > C360)
        begin
            angle_w = angle_w - C360;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            bad_reg <= 1'b0;
            yaw_bad_reg <= 1'b0;
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
            out_valid_reg <= 1'b0;
            term_reg <= '0;
            sel_reg <= '0;
            i_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                term_reg <= '0;
                if (sx == '0 && sy == '0 && sz == '0)
                begin
                    bad_reg <= 1'b1;
                end
                if (sx == '0 && sz == '0)
                begin
                    yaw_bad_reg <= 1'b1;
                end
            end
            if (cmd.root_init || cmd.cord_init)
            begin
                i_reg <= '0;
                last_reg <= CW'(STEPS - 1);
            end
            if (cmd.div_init)
            begin
                i_reg <= '0;
                last_reg <= '0;
            end
            if (cmd.root_step || cmd.cord_step || cmd.div_step)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.acc)
            begin
                term_reg <= term_reg + 1'b1;
                if (en_reg)
                begin
                    sum_reg[term_reg] <= sum_reg[term_reg] + SW'(term);
                end
            end
            if (cmd.count)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.div_step && stat.iter_last)
            begin
                sel_reg <= sel_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
                bad_reg <= 1'b0;
                yaw_bad_reg <= 1'b0;
                sum_reg[0] <= '0;
                sum_reg[1] <= '0;
                sum_reg[2] <= '0;
                sel_reg <= '0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= sx;
            ay_reg <= sy;
            az_reg <= sz;
            all0_reg <= (sx == '0 && sy == '0 && sz == '0);
            yaw0_reg <= (sx == '0 && sz == '0);
        end
        if (cmd.setup)
        begin
            case (term_reg)
                2'd0:
                begin
                    a_reg <= ax_reg;
                    b_reg <= ay_reg;
                    c_reg <= az_reg;
                    en_reg <= !all0_reg;
                end
                2'd1:
                begin
                    a_reg <= ay_reg;
                    b_reg <= ax_reg;
                    c_reg <= az_reg;
                    en_reg <= !all0_reg;
                end
                default:
                begin
                    a_reg <= az_reg;
                    b_reg <= ax_reg;
                    c_reg <= az_reg;
                    en_reg <= !yaw0_reg;
                end
            endcase
        end
        if (cmd.sq1)
        begin
            s_reg <= prod;
        end
        if (cmd.sq2)
        begin
            s_reg <= s_reg + prod;
        end
        if (cmd.root_init)
        begin
            n_reg <= {s_reg, 16'b0};
            res_reg <= '0;
            bit_reg <= QW'(1) << (QW - 2);
        end
        if (cmd.root_step)
        begin
            if (n_reg >= root_try)
            begin
                n_reg <= n_reg - root_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.cord_init)
        begin
            x_reg <= $signed(XW'(res_reg));
            y_reg <= XW'(a_reg) <<< 8;
            z_reg <= '0;
        end
        if (cmd.cord_step)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_q24(i_reg[4:0]);
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_q24(i_reg[4:0]);
            end
        end
        if (cmd.div_init)
        begin
            dvd_reg <= div_mag;
        end
        if (cmd.div_step)
        begin
            if (stat.iter_last)
            begin
                avg_reg[sel_reg] <= (sum_sel < 0) ? -AW'($signed({1'b0, quot}))
                                                  : AW'($signed({1'b0, quot}));
            end
        end
        if (cmd.emit)
        begin
            tilt_reg <= angle_w[17:0];
        end
    end

    assign stat.iter_last = (i_reg == last_reg);
    assign stat.term_last = (term_reg == 2'd2);
    assign stat.batch_end = (({1'b0, cnt_reg} + 1'b1) >= (NW+1)'(N));
    assign stat.batch_bad = bad_reg;
    assign stat.div_last = (sel_reg == 2'd2);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign tilt_angle = tilt_reg;

endmodule

// ----- rtl/core/accel_tilt_angle_averager.sv -----
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   sample_first, sample_second, sample_third
// out      source     out_valid/out_stall tilt_angle
// cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each sample passes through an accept step, three tilt terms, each built by the
// 24-step shared square root and the 24-step shared CORDIC arctangent, and a batch
// count step.
// The last sample of a batch adds an initialise and a divide step per sum for the
// reciprocal-multiply average, and an emit step that waits for a free output register.
// Reset clears the batch state and loads the register defaults.
// A stalled result holds in the output register while the next sample is taken;
// the next batch result waits until that register is free.
module accel_tilt_angle_averager #(
    parameter int SAMPLES_PER_ANGLE = tilt_pkg::SAMPLES_DEF,
    parameter int FRAC_BITS = tilt_pkg::FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_first,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_second,
    input  logic signed [tilt_pkg::AXIS_W-1:0]  sample_third,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [17:0]                  tilt_angle,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_index,
    input  logic [9:0]                          cfg_data
);
    import tilt_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_select <= AXIS_X;
            cfg_reg.swap_y_z <= 1'b0;
            cfg_reg.gain_x <= 4'd1;
            cfg_reg.gain_y <= 4'd1;
            cfg_reg.gain_z <= 4'd1;
            cfg_reg.angle_offset <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AXIS_SELECT:  cfg_reg.axis_select <= cfg_data[1:0];
                CFG_SWAP_Y_Z:     cfg_reg.swap_y_z <= cfg_data[0];
                CFG_GAIN_X:       cfg_reg.gain_x <= cfg_data[3:0];
                CFG_GAIN_Y:       cfg_reg.gain_y <= cfg_data[3:0];
                CFG_GAIN_Z:       cfg_reg.gain_z <= cfg_data[3:0];
                CFG_ANGLE_OFFSET: cfg_reg.angle_offset <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    tilt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tilt_dp #(
        .SAMPLES_PER_ANGLE (SAMPLES_PER_ANGLE),
        .FRAC_BITS         (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg           (cfg_reg),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .sample_third  (sample_third),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tilt_angle    (tilt_angle)
    );

    a_load_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && !in_stall))
        else $error("sample loaded without an accepted request");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled while a sample is in work");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.emit))
        else $error("result appeared without an emit command");

    a_single_command: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.emit || !cmd.load)
        else $error("emit and load in the same cycle");

endmodule

// ----- verif/tb_accel_tilt_angle_averager.sv -----
module tb_accel_tilt_angle_averager;
    import tilt_pkg::*;

    localparam int BATCH = SAMPLES_DEF;
    localparam int ONE = 1 << FRAC_DEF;
    localparam int SETTLE = 400;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 197;

    typedef struct {
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic signed [15:0] s3;
        bit                 typed;
        logic [17:0]        angle;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] sample_first = '0;
    logic signed [15:0] sample_second = '0;
    logic signed [15:0] sample_third = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [17:0] tilt_angle;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;

    logic [1:0] m_axis;
    bit m_swap;
    logic signed [3:0] m_gx, m_gy, m_gz;
    logic signed [9:0] m_offset;
    int m_count;
    longint m_sum_pitch, m_sum_roll, m_sum_yaw;
    bit m_batch_bad, m_yaw_bad;

    logic [17:0] angle_q[$];
    int mismatches = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int stall_left = 0;
    row_t rows[$];

    accel_tilt_angle_averager dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_first(sample_first), .sample_second(sample_second),
        .sample_third(sample_third),
        .out_valid(out_valid), .out_stall(out_stall), .tilt_angle(tilt_angle),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_q(longint z);
        longint mag, r;
        mag = (z < 0) ? -z : z;
        r = (mag + (64'sd1 << (23 - FRAC_DEF))) >>> (24 - FRAC_DEF);
        return (z < 0) ? -r : r;
    endfunction

    function automatic longint tilt_deg(longint a, longint b, longint c);
        longint s, x, y, z, dx, dy;
        z = 0;
        if (a == 0)
            return 0;
        s = b * b + c * c;
        if (s == 0)
            return round_q(a > 0 ? longint'(Q24_90) : -longint'(Q24_90));
        x = longint'(int_sqrt(longint'(s) << 16));
        y = a * 256;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q24(5'(i)));
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q24(5'(i)));
            end
        end
        if (z > longint'(Q24_90))
            z = Q24_90;
        if (z < -longint'(Q24_90))
            z = -longint'(Q24_90);
        return round_q(z);
    endfunction

    function automatic longint apply_gain(logic signed [15:0] raw, logic signed [3:0] g);
        longint p;
        logic signed [15:0] w;
        p = longint'(raw) * longint'(g);
        w = p[15:0];
        return longint'(w);
    endfunction

    function automatic longint batch_mean(longint sum);
        longint mag, r;
        mag = (sum < 0) ? -sum : sum;
        r = (mag + BATCH / 2) / BATCH;
        return (sum < 0) ? -r : r;
    endfunction

    function automatic void clear_batch();
        m_count = 0;
        m_sum_pitch = 0;
        m_sum_roll = 0;
        m_sum_yaw = 0;
        m_batch_bad = 1'b0;
        m_yaw_bad = 1'b0;
    endfunction

    function automatic bit predict_angle(logic signed [15:0] s1, logic signed [15:0] s2,
                                         logic signed [15:0] s3, output logic [17:0] res);
        longint ax, ay, az, xs, ys, zs, xa, ya, za, xv, yv, zv, ang;
        xv = 0;
        yv = 0;
        zv = 0;
        res = '0;
        ax = apply_gain(s1, m_gx);
        ay = apply_gain(m_swap ? s3 : s2, m_gy);
        az = apply_gain(m_swap ? s2 : s3, m_gz);
        if (ax == 0 && ay == 0 && az == 0)
            m_batch_bad = 1'b1;
        else
        begin
            m_sum_pitch += tilt_deg(ax, ay, az);
            m_sum_roll += tilt_deg(ay, ax, az);
        end
        if (ax == 0 && az == 0)
            m_yaw_bad = 1'b1;
        else
            m_sum_yaw += tilt_deg(az, ax, az);
        m_count++;
        if (m_count < BATCH)
            return 1'b0;
        if (m_batch_bad)
        begin
            clear_batch();
            return 1'b0;
        end
        xs = m_sum_pitch;
        ys = m_sum_roll;
        zs = m_sum_yaw;
        xa = batch_mean(xs);
        ya = batch_mean(ys);
        za = batch_mean(zs);
        if (xs < 0 && ys > 0) xv = -xa;
        if (xs < 0 && ys < 0) xv = 180 * ONE + xa;
        if (xs > 0 && ys < 0) xv = 180 * ONE + xa;
        if (xs > 0 && ys > 0) xv = 360 * ONE - xa;
        if (ys != 0 && xs < 0) yv = 90 * ONE - ya;
        if (ys != 0 && xs > 0) yv = 270 * ONE + ya;
        if (!m_yaw_bad)
        begin
            if (zs != 0 && xs < 0) zv = 90 * ONE - za;
            if (zs != 0 && xs > 0) zv = 270 * ONE + za;
        end
        case (m_axis)
            AXIS_X: ang = xv;
            AXIS_Y: ang = yv;
            AXIS_Z: ang = zv;
            default: ang = 0;
        endcase
        ang = ang + longint'(m_offset) * ONE;
        if (ang > 360 * ONE)
            ang = ang - 360 * ONE;
        res = ang[17:0];
        clear_batch();
        return 1'b1;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            CFG_AXIS_SELECT: m_axis = val[1:0];
            CFG_SWAP_Y_Z: m_swap = val[0];
            CFG_GAIN_X: m_gx = val[3:0];
            CFG_GAIN_Y: m_gy = val[3:0];
            CFG_GAIN_Z: m_gz = val[3:0];
            CFG_ANGLE_OFFSET: m_offset = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_sample(logic signed [15:0] s1, logic signed [15:0] s2,
                               logic signed [15:0] s3, bit typed, logic [17:0] typed_angle);
        logic [17:0] res;
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample_first = s1;
        sample_second = s2;
        sample_third = s3;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        if (predict_angle(s1, s2, s3, res))
            angle_q.push_back(typed ? typed_angle : res);
    endtask

    task automatic random_sample();
        logic signed [15:0] a, b, c;
        int mode;
        mode = $urandom_range(0, 99);
        a = 16'($urandom);
        b = 16'($urandom);
        c = 16'($urandom);
        if (mode < 2)
        begin
            a = '0;
            b = '0;
            c = '0;
        end
        else if (mode < 6)
        begin
            a = '0;
            if (m_swap)
                b = '0;
            else
                c = '0;
        end
        else if (mode < 12)
        begin
            a = 16'($signed($urandom_range(0, 8)) - 4);
            b = 16'($signed($urandom_range(0, 8)) - 4);
            c = 16'($signed($urandom_range(0, 8)) - 4);
        end
        send_sample(a, b, c, 1'b0, '0);
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = 8000;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            out_stall = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (angle_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected angle %0d", tilt_angle);
            end
            else
            begin
                if (tilt_angle !== angle_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tilt_angle expected %0d actual %0d",
                                 $signed(angle_q[0]), tilt_angle);
                end
                void'(angle_q.pop_front());
            end
        end
    end

    initial
    begin
        #4000000;
        $display("accel_tilt_angle_averager verification failed");
        $finish;
    end

    initial
    begin
        row_t r;
        int lim;
        m_axis = AXIS_X;
        m_swap = 1'b0;
        m_gx = 1;
        m_gy = 1;
        m_gz = 1;
        m_offset = 0;
        clear_batch();

        for (int i = 0; i < BATCH; i++)
        begin
            r = '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0};
            rows.push_back(r);
        end
        for (int i = 0; i < BATCH; i++)
        begin
            r = '{16'sd32767, 16'sd0, 16'sd0, i == BATCH - 1, '0};
            rows.push_back(r);
        end
        r = '{16'sd0, -16'sd32768, 16'sd0, 1'b0, '0};
        rows.push_back(r);
        r = '{16'sd0, 16'sd32767, 16'sd0, 1'b0, '0};
        rows.push_back(r);
        r = '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0};
        rows.push_back(r);
        r = '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0};
        rows.push_back(r);
        r = '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0};
        rows.push_back(r);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_sample(rows[i].s1, rows[i].s2, rows[i].s3, rows[i].typed, rows[i].angle);

        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            wait_drained();
            case (p)
                1:
                begin
                    write_reg(CFG_AXIS_SELECT, 10'(AXIS_X));
                    write_reg(CFG_SWAP_Y_Z, 10'd1);
                    write_reg(CFG_GAIN_X, 10'h3fc);
                    write_reg(CFG_GAIN_Y, 10'h3fc);
                    write_reg(CFG_GAIN_Z, 10'h3fc);
                    write_reg(CFG_ANGLE_OFFSET, 10'h298);
                end
                2:
                begin
                    write_reg(CFG_AXIS_SELECT, 10'(AXIS_Z));
                    write_reg(CFG_SWAP_Y_Z, 10'd0);
                    write_reg(CFG_GAIN_X, 10'd4);
                    write_reg(CFG_GAIN_Y, 10'd4);
                    write_reg(CFG_GAIN_Z, 10'd4);
                    write_reg(CFG_ANGLE_OFFSET, 10'd360);
                end
                3:
                begin
                    write_reg(CFG_AXIS_SELECT, 10'd3);
                    write_reg(CFG_GAIN_X, 10'd1);
                    write_reg(CFG_GAIN_Y, 10'd1);
                    write_reg(CFG_GAIN_Z, 10'd1);
                end
                default:
                begin
                    write_reg(CFG_AXIS_SELECT, 10'($urandom_range(0, 2)));
                    write_reg(CFG_SWAP_Y_Z, 10'($urandom_range(0, 1)));
                    write_reg(CFG_GAIN_X, 10'($signed($urandom_range(0, 8)) - 4));
                    write_reg(CFG_GAIN_Y, 10'($signed($urandom_range(0, 8)) - 4));
                    write_reg(CFG_GAIN_Z, 10'($signed($urandom_range(0, 8)) - 4));
                    write_reg(CFG_ANGLE_OFFSET, 10'($signed($urandom_range(0, 720)) - 360));
                end
            endcase
            if (p == 4)
                hold_req = 1'b1;
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_sample();
        end
        @(negedge clk);
        in_valid = 1'b0;

        lim = 0;
        while (angle_q.size() != 0 && lim < 100000)
        begin
            @(posedge clk);
            lim++;
        end
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && angle_q.size() == 0)
            $display("accel_tilt_angle_averager verification clean");
        else
            $display("accel_tilt_angle_averager verification failed");
        $finish;
    end
endmodule
